// ===== rtl/ufs_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 file name sanitizer.
package ufs_pkg;

  // Longest name in bytes
  localparam int unsigned NAME_LIMIT = 100;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] CHAR_SPACE      = 8'd32;
  localparam logic [7:0] CHAR_DOT        = 8'd46;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'd95;
  localparam logic [7:0] CHAR_DEL        = 8'd127;

  // One unit of work for the back end: a finished sequence or an end of string
  typedef struct packed {
    logic            is_end;     // end of string: optional underscore, then length
    logic [2:0]      n_items;    // results this command expands into (1..4)
    logic [6:0]      start_pos;  // position of the first byte
    logic [6:0]      flen;       // final length for an end command
    logic [3:0][7:0] bytes;      // sequence bytes, first in entry 0
  } cmd_t;

  // Characters not allowed in a path component
  function automatic logic is_path_char(input logic [7:0] c);
    return (c == 8'd47) || (c == 8'd92) || (c == 8'd58) || (c == 8'd42) ||
           (c == 8'd63) || (c == 8'd34) || (c == 8'd60) || (c == 8'd62) ||
           (c == 8'd124);
  endfunction

  // Bytes that the trailing trim removes
  function automatic logic is_trim_char(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_DOT);
  endfunction

endpackage

// ===== rtl/ufs_front.sv =====
// Front end: accepts text bytes, gathers UTF-8 sequences and issues commands.
module ufs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          q_full_i,
  output logic          push_o,
  output ufs_pkg::cmd_t cmd_o
);

  logic [6:0]      wcount_q, wcount_d;
  logic [6:0]      keep_q, keep_d;
  logic [2:0][7:0] held_q;
  logic [2:0]      hcount_q, hcount_d;
  logic [2:0]      explen_q, explen_d;
  logic            stopped_q, stopped_d;

  logic            accept;
  logic            is_end;
  logic [2:0]      lead_len;
  logic            fits;
  logic            completes;
  logic            held_we;
  logic [3:0][7:0] seq_bytes;
  logic [7:0]      single_byte;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && !q_full_i;
  assign is_end     = (in_byte_i == 8'd0);

  // Sequence length from the lead byte
  always_comb begin
    if (in_byte_i < 8'd128) begin
      lead_len = 3'd1;
    end else if (in_byte_i < 8'd224) begin
      lead_len = 3'd2;
    end else if (in_byte_i < 8'd240) begin
      lead_len = 3'd3;
    end else begin
      lead_len = 3'd4;
    end
  end

  assign fits = ({1'b0, wcount_q} + {5'b0, lead_len}) <= 8'(ufs_pkg::NAME_LIMIT);
  assign completes = (explen_q != 3'd0) && ((hcount_q + 3'd1) == explen_q);

  assign single_byte = ((in_byte_i < ufs_pkg::CHAR_SPACE) ||
                        (in_byte_i == ufs_pkg::CHAR_DEL) ||
                        ufs_pkg::is_path_char(in_byte_i)) ?
                       ufs_pkg::CHAR_UNDERSCORE : in_byte_i;

  // Assemble the finished sequence: held bytes, then the current byte
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      seq_bytes[i] = (3'(i) < hcount_q) ? held_q[i] : in_byte_i;
    end
    seq_bytes[3] = in_byte_i;
  end

  // Classify the request and work out the next state
  always_comb begin
    wcount_d  = wcount_q;
    keep_d    = keep_q;
    hcount_d  = hcount_q;
    explen_d  = explen_q;
    stopped_d = stopped_q;
    held_we   = 1'b0;
    push_o    = 1'b0;
    cmd_o     = '0;
    if (accept) begin
      priority if (is_end) begin
        push_o          = 1'b1;
        cmd_o.is_end    = 1'b1;
        cmd_o.n_items   = (keep_q == 7'd0) ? 3'd2 : 3'd1;
        cmd_o.flen      = (keep_q == 7'd0) ? 7'd1 : keep_q;
        cmd_o.bytes[0]  = ufs_pkg::CHAR_UNDERSCORE;
        wcount_d        = '0;
        keep_d          = '0;
        hcount_d        = '0;
        explen_d        = '0;
        stopped_d       = 1'b0;
      end else if (stopped_q) begin
        // drop the rest of the string
      end else if (explen_q == 3'd0) begin
        if (!fits) begin
          stopped_d = 1'b1;
        end else if (lead_len == 3'd1) begin
          push_o          = 1'b1;
          cmd_o.n_items   = 3'd1;
          cmd_o.start_pos = wcount_q;
          cmd_o.bytes[0]  = single_byte;
          wcount_d        = wcount_q + 7'd1;
          if (!ufs_pkg::is_trim_char(single_byte)) begin
            keep_d = wcount_q + 7'd1;
          end
        end else begin
          held_we  = 1'b1;
          hcount_d = 3'd1;
          explen_d = lead_len;
        end
      end else if (completes) begin
        push_o          = 1'b1;
        cmd_o.n_items   = explen_q;
        cmd_o.start_pos = wcount_q;
        cmd_o.bytes     = seq_bytes;
        wcount_d        = wcount_q + {4'b0, explen_q};
        for (int i = 0; i < 4; i++) begin
          if ((3'(i) < explen_q) && !ufs_pkg::is_trim_char(seq_bytes[i])) begin
            keep_d = wcount_q + 7'(i + 1);
          end
        end
        hcount_d = '0;
        explen_d = '0;
      end else begin
        held_we  = 1'b1;
        hcount_d = hcount_q + 3'd1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wcount_q  <= '0;
      keep_q    <= '0;
      hcount_q  <= '0;
      explen_q  <= '0;
      stopped_q <= 1'b0;
    end else begin
      wcount_q  <= wcount_d;
      keep_q    <= keep_d;
      hcount_q  <= hcount_d;
      explen_q  <= explen_d;
      stopped_q <= stopped_d;
    end
  end

  // Hold the bytes of a partly gathered sequence
  always_ff @(posedge clk_i) begin
    if (held_we) begin
      held_q[hcount_q[1:0]] <= in_byte_i;
    end
  end

endmodule

// ===== rtl/ufs_queue.sv =====
// Short command queue between the front and back ends.
module ufs_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  ufs_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output ufs_pkg::cmd_t cmd_o
);

  localparam int unsigned CntW = ufs_pkg::QPTR_W + 1;

  ufs_pkg::cmd_t                    slots_q [ufs_pkg::QUEUE_DEPTH];
  logic [ufs_pkg::QPTR_W-1:0]       wptr_q, wptr_d;
  logic [ufs_pkg::QPTR_W-1:0]       rptr_q, rptr_d;
  logic [CntW-1:0]                  count_q, count_d;

  assign full_o  = (count_q == CntW'(ufs_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = slots_q[rptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wptr_d  = push_i ? wptr_q + 1'b1 : wptr_q;
    rptr_d  = pop_i ? rptr_q + 1'b1 : rptr_q;
    count_d = count_q + CntW'(push_i) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// ===== rtl/ufs_back.sv =====
// Back end: expands queued commands into result items behind an output register.
module ufs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  ufs_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [6:0]    position_o,
  output logic [7:0]    out_byte_o,
  output logic          is_length_o,
  output logic [6:0]    final_length_o,
  output logic          last_o
);

  logic [1:0] idx_q, idx_d;
  logic       ovalid_q, ovalid_d;
  logic [6:0] pos_q, pos_d;
  logic [7:0] byte_q, byte_d;
  logic       islen_q, islen_d;
  logic [6:0] flen_q, flen_d;
  logic       last_q, last_d;
  logic       load;
  logic       last_item;

  assign load      = cmd_valid_i && (!ovalid_q || out_ready_i);
  assign last_item = ({1'b0, idx_q} == (cmd_i.n_items - 3'd1));
  assign pop_o     = load && last_item;

  // Form the next result from the head command
  always_comb begin
    islen_d = cmd_i.is_end && last_item;
    last_d  = last_item;
    flen_d  = islen_d ? cmd_i.flen : 7'd0;
    if (islen_d) begin
      byte_d = 8'd0;
      pos_d  = 7'd0;
    end else if (cmd_i.is_end) begin
      byte_d = ufs_pkg::CHAR_UNDERSCORE;
      pos_d  = 7'd0;
    end else begin
      byte_d = cmd_i.bytes[idx_q];
      pos_d  = cmd_i.start_pos + {5'b0, idx_q};
    end
    idx_d    = load ? (last_item ? 2'd0 : idx_q + 2'd1) : idx_q;
    ovalid_d = load ? 1'b1 : (out_ready_i ? 1'b0 : ovalid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      idx_q    <= idx_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Output payload register
  always_ff @(posedge clk_i) begin
    if (load) begin
      pos_q   <= pos_d;
      byte_q  <= byte_d;
      islen_q <= islen_d;
      flen_q  <= flen_d;
      last_q  <= last_d;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign position_o     = pos_q;
  assign out_byte_o     = byte_q;
  assign is_length_o    = islen_q;
  assign final_length_o = flen_q;
  assign last_o         = last_q;

endmodule

// ===== rtl/utf8_filename_sanitizer_core.sv =====
// Top level of the UTF-8 file name sanitizer.
// Input stream: one text byte per request in s_axis_tdata; a zero byte ends
// the string. Output stream: one result per request; a result is either a
// kept byte with its position in the name or, at the end of the string, the
// final length after trailing spaces and dots are trimmed. m_axis_tlast
// marks the last result caused by one input byte.
// Throughput: one input byte per cycle while the receiver is ready and the
// bytes cause at most one result each on average. A completed UTF-8
// sequence of n bytes leaves as n results, one per cycle unless stalled,
// from the back end; an empty name gives two results (underscore, then
// length), so a run of empty names halves the input rate. The command for
// a completing byte is registered in the command queue, and each result
// then in the back end output register. The four-entry command queue absorbs
// bursts; the input stalls only when the queue is full.
// Reset clears the name state, the queue and the output valid flag; the
// block accepts input once reset is released. When the receiver holds
// m_axis_tready low the output result is held and the queue fills.
module utf8_filename_sanitizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] char_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // [6:0] position, [14:7] out_byte,
                                     // [15] is_length, [22:16] final_length
  output logic        m_axis_tlast
);

  ufs_pkg::cmd_t push_cmd;
  ufs_pkg::cmd_t head_cmd;
  logic          push;
  logic          full;
  logic          pop;
  logic          head_valid;
  logic [6:0]    position;
  logic [7:0]    out_byte;
  logic          is_length;
  logic [6:0]    final_length;

  ufs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .q_full_i   (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  ufs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .cmd_o   (head_cmd)
  );

  ufs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (head_valid),
    .cmd_i          (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .position_o     (position),
    .out_byte_o     (out_byte),
    .is_length_o    (is_length),
    .final_length_o (final_length),
    .last_o         (m_axis_tlast)
  );

  // Pack the result fields, lowest first
  assign m_axis_tdata = {1'b0, final_length, is_length, out_byte, position};

endmodule

// ===== rtl/ufs_checker.sv =====
// Port-level checks for the file name sanitizer, bound to the top level.
module ufs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // A length result always closes the results of its input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[15] |-> m_axis_tlast &&
      m_axis_tdata[6:0] == 7'd0 && m_axis_tdata[14:7] == 8'd0)
    else $error("malformed length result");

  // Final length lies within 1 and the name limit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[15] |->
      m_axis_tdata[22:16] != 7'd0 &&
      m_axis_tdata[22:16] <= 7'(ufs_pkg::NAME_LIMIT))
    else $error("final length out of range");

  // Byte results stay inside the name and carry no length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[15] |->
      m_axis_tdata[6:0] < 7'(ufs_pkg::NAME_LIMIT) && m_axis_tdata[22:16] == 7'd0)
    else $error("byte result out of range");

endmodule

bind utf8_filename_sanitizer_core ufs_checker u_ufs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
